### rtl/kace_pkg.sv
`timescale 1ns / 1ps
package kace_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEER_STEP    = 8'd0,
    REG_STEER_CENTER  = 8'd1,
    REG_STEER_MAX     = 8'd2,
    REG_PEDAL_STEP    = 8'd3,
    REG_PEDAL_MAX     = 8'd4,
    REG_SOFT_BRAKE    = 8'd5,
    REG_HARD_BRAKE    = 8'd6
  } cfg_reg_e;

  // reset values
  localparam logic [7:0] SteerStepRst   = 8'd32;
  localparam logic [7:0] SteerCenterRst = 8'd128;
  localparam logic [7:0] SteerMaxRst    = 8'd254;
  localparam logic [7:0] PedalStepRst   = 8'd2;
  localparam logic [7:0] PedalMaxRst    = 8'd254;
  localparam logic [7:0] SoftBrakeRst   = 8'h80;
  localparam logic [7:0] HardBrakeRst   = 8'hFF;
  localparam logic [7:0] SteerPosRst    = 8'd128;
  localparam logic [5:0] HeldPrevRst    = 6'd63;

  typedef struct packed {
    logic [5:0] button_keys;
    logic       steer_left;
    logic       steer_right;
    logic       left_pedal_key;
    logic       right_pedal_key;
    logic       soft_brake_key;
    logic       hard_brake_key;
  } in_item_t;

  typedef struct packed {
    logic [5:0] buttons_held;
    logic [5:0] buttons_pressed;
    logic [7:0] steering;
    logic [7:0] left_velocity;
    logic [7:0] right_velocity;
    logic [7:0] left_change;
    logic [7:0] right_change;
    logic       left_rising;
    logic       right_rising;
    logic [7:0] brake;
  } out_item_t;

  typedef struct packed {
    logic [7:0] step;
    logic [7:0] center;
    logic [7:0] max;
  } steer_cfg_t;

  typedef struct packed {
    logic [7:0] step;
    logic [7:0] max;
  } pedal_cfg_t;

  typedef struct packed {
    logic [7:0] velocity;
    logic [7:0] change;
    logic       rising;
  } pedal_res_t;

endpackage

### rtl/kace_steer.sv
`timescale 1ns / 1ps
module kace_steer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               update_i,
  input  logic               left_i,
  input  logic               right_i,
  input  kace_pkg::steer_cfg_t cfg_i,
  output logic [7:0]         pos_o
);
  import kace_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] after_left;
  logic [8:0] right_sum;
  logic [7:0] after_right;
  logic [8:0] ret_sum;
  logic [8:0] center_plus;
  logic [7:0] returned;

  // left move first, then right move
  always_comb begin
    after_left  = (pos_q <= cfg_i.step) ? 8'd0 : pos_q - cfg_i.step;
    right_sum   = {1'b0, (left_i ? after_left : pos_q)} + {1'b0, cfg_i.step};
    after_right = (right_sum >= {1'b0, cfg_i.max}) ? cfg_i.max : right_sum[7:0];
  end

  // return to center without overshoot
  always_comb begin
    ret_sum     = {1'b0, pos_q} + {1'b0, cfg_i.step};
    center_plus = {1'b0, cfg_i.center} + {1'b0, cfg_i.step};
    if (pos_q <= cfg_i.center) begin
      returned = (ret_sum >= {1'b0, cfg_i.center}) ? cfg_i.center : ret_sum[7:0];
    end else begin
      returned = ({1'b0, pos_q} <= center_plus) ? cfg_i.center : pos_q - cfg_i.step;
    end
  end

  always_comb begin
    if (right_i) begin
      pos_d = after_right;
    end else if (left_i) begin
      pos_d = after_left;
    end else begin
      pos_d = returned;
    end
  end

  assign pos_o = pos_d;

  // position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= SteerPosRst;
    end else if (update_i) begin
      pos_q <= pos_d;
    end
  end

endmodule

### rtl/kace_pedal.sv
`timescale 1ns / 1ps
module kace_pedal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 update_i,
  input  logic                 key_i,
  input  kace_pkg::pedal_cfg_t cfg_i,
  output kace_pkg::pedal_res_t res_o
);
  import kace_pkg::*;

  logic [7:0] vel_q, vel_d;
  logic [7:0] chg_q, chg_d;
  logic [8:0] up_sum;
  logic [8:0] stepped;

  // ramp up or down, then clamp to max
  always_comb begin
    up_sum = {1'b0, vel_q} + {1'b0, cfg_i.step};
    if (key_i) begin
      stepped = up_sum;
    end else begin
      stepped = (vel_q > cfg_i.step) ? {1'b0, vel_q - cfg_i.step} : 9'd0;
    end
    vel_d = (stepped > {1'b0, cfg_i.max}) ? cfg_i.max : stepped[7:0];
    chg_d = (vel_d >= vel_q) ? vel_d - vel_q : vel_q - vel_d;
  end

  assign res_o.velocity = vel_d;
  assign res_o.change   = chg_d;
  assign res_o.rising   = (chg_q < chg_d);

  // velocity and last change
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      chg_q <= '0;
    end else if (update_i) begin
      vel_q <= vel_d;
      chg_q <= chg_d;
    end
  end

endmodule

### rtl/key_to_analog_control_emulator_top.sv
`timescale 1ns / 1ps
// Key-to-analog control emulator.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one tick of key
// states; output channel (out_valid_o / out_ready_i / out_data_o) returns one
// result per tick: remapped buttons with press edges, steering position, two
// pedal velocities with change and rising flags, and the brake level.
// Each transfer is captured in an input register, worked out by the
// add/clamp/compare logic and placed in the result register. One item per
// cycle is sustained while the receiver does not stall; the only loop is the
// steering and pedal state feedback. When the receiver stalls, the result
// register holds and the input register holds the next item; in_ready_o
// drops only when both are full. Configuration is a plain write port
// (cfg_we_i, cfg_index_i, cfg_wdata_i), to be written only while the block
// is idle, which it does not check itself; unknown indexes are ignored.
// Reset clears both pipeline stages, loads the register defaults, centers the
// steering at 128, zeroes the pedals and marks all buttons as held before.
module key_to_analog_control_emulator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kace_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kace_pkg::out_item_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [kace_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kace_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import kace_pkg::*;

  // configuration registers
  steer_cfg_t steer_cfg_q;
  pedal_cfg_t pedal_cfg_q;
  logic [7:0] soft_lvl_q, hard_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_cfg_q.step   <= SteerStepRst;
      steer_cfg_q.center <= SteerCenterRst;
      steer_cfg_q.max    <= SteerMaxRst;
      pedal_cfg_q.step   <= PedalStepRst;
      pedal_cfg_q.max    <= PedalMaxRst;
      soft_lvl_q         <= SoftBrakeRst;
      hard_lvl_q         <= HardBrakeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEER_STEP:   steer_cfg_q.step   <= cfg_wdata_i;
        REG_STEER_CENTER: steer_cfg_q.center <= cfg_wdata_i;
        REG_STEER_MAX:    steer_cfg_q.max    <= cfg_wdata_i;
        REG_PEDAL_STEP:   pedal_cfg_q.step   <= cfg_wdata_i;
        REG_PEDAL_MAX:    pedal_cfg_q.max    <= cfg_wdata_i;
        REG_SOFT_BRAKE:   soft_lvl_q         <= cfg_wdata_i;
        REG_HARD_BRAKE:   hard_lvl_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q, out_d;
  logic      advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // button remap and press edges
  logic [5:0] held_prev_q;
  logic [5:0] held;

  assign held = {in_q.button_keys[5], in_q.button_keys[4], in_q.button_keys[2],
                 in_q.button_keys[0], in_q.button_keys[1], in_q.button_keys[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_prev_q <= HeldPrevRst;
    end else if (advance) begin
      held_prev_q <= held;
    end
  end

  // steering and pedals
  logic [7:0] steer_pos;
  pedal_res_t left_res, right_res;

  kace_steer u_steer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .left_i   (in_q.steer_left),
    .right_i  (in_q.steer_right),
    .cfg_i    (steer_cfg_q),
    .pos_o    (steer_pos)
  );

  kace_pedal u_pedal_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .key_i    (in_q.left_pedal_key),
    .cfg_i    (pedal_cfg_q),
    .res_o    (left_res)
  );

  kace_pedal u_pedal_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .key_i    (in_q.right_pedal_key),
    .cfg_i    (pedal_cfg_q),
    .res_o    (right_res)
  );

  // result assembly, hard brake over soft
  always_comb begin
    out_d.buttons_held    = held;
    out_d.buttons_pressed = held & ~held_prev_q;
    out_d.steering        = steer_pos;
    out_d.left_velocity   = left_res.velocity;
    out_d.right_velocity  = right_res.velocity;
    out_d.left_change     = left_res.change;
    out_d.right_change    = right_res.change;
    out_d.left_rising     = left_res.rising;
    out_d.right_rising    = right_res.rising;
    if (in_q.hard_brake_key) begin
      out_d.brake = hard_lvl_q;
    end else if (in_q.soft_brake_key) begin
      out_d.brake = soft_lvl_q;
    end else begin
      out_d.brake = '0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
